/* hw/rtl/pfre_pkg.sv */
package pfre_pkg;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned WIN_W     = 8;
  localparam int unsigned TPS_W     = 24;
  localparam int unsigned FR_W      = 8;
  localparam int unsigned RATE_W    = 24;
  localparam int unsigned QUOT_W    = WIN_W + TPS_W;
  localparam int unsigned CNT_W     = $clog2(QUOT_W);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 2'd3;

  // configuration reset values
  localparam logic [TIME_W-1:0] GAP_LIMIT_RST = TIME_W'(5 * 1000 * 1000);
  localparam logic [WIN_W-1:0]  WIN_FRAMES_RST = WIN_W'(60);
  localparam logic [TPS_W-1:0]  TICKS_PER_SEC_RST = TPS_W'(1000000);
  localparam logic [FR_W-1:0]   RATE_LIMIT_RST = FR_W'(80);

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] pts;
    logic [TIME_W-1:0] arrival_time;
  } pfre_in_t;

  typedef struct packed {
    logic [FR_W-1:0] frame_rate;
    logic            rate_changed;
    logic            updated;
  } pfre_out_t;

  // controller to datapath, one strobe per step
  typedef struct packed {
    logic load;
    logic gap;
    logic interval;
    logic skip;
    logic jump;
    logic win_start;
    logic win_finish;
    logic init_start;
    logic init_finish;
    logic tail;
    logic limit;
    logic emit;
  } pfre_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic upd;
    logic iv_ok;
    logic win_go;
    logic init_go;
    logic div_done;
    logic out_free;
  } pfre_stat_t;

endpackage

/* hw/rtl/pfre_div.sv */
module pfre_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pfre_pkg::QUOT_W-1:0]  dividend_i,
  input  logic [pfre_pkg::TIME_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [pfre_pkg::QUOT_W-1:0]  quo_o,
  output logic                         round_o
);
  import pfre_pkg::*;

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0] quo_q, quo_d;
  logic [TIME_W-1:0] dvs_q, dvs_d;

  logic [TIME_W:0]   rem_sh;
  logic [TIME_W+1:0] diff;
  logic              last;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[QUOT_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign last   = cnt_q == CNT_W'(QUOT_W - 1);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[TIME_W+1]) begin
        rem_d = diff[TIME_W-1:0];
      end else begin
        rem_d = rem_sh[TIME_W-1:0];
      end
      quo_d = {quo_q[QUOT_W-2:0], ~diff[TIME_W+1]};
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o  = busy_q && last;
  assign quo_o   = quo_q;
  assign round_o = rem_q > {1'b0, dvs_q[TIME_W-1:1]};

endmodule

/* hw/rtl/pfre_dp.sv */
module pfre_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfre_pkg::pfre_cmd_t            cmd_i,
  output pfre_pkg::pfre_stat_t           stat_o,
  input  pfre_pkg::pfre_in_t             in_data_i,
  input  logic                           cfg_we_i,
  input  logic [pfre_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pfre_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output pfre_pkg::pfre_out_t            out_data_o
);
  import pfre_pkg::*;

  // configuration
  logic [TIME_W-1:0] gap_limit_q;
  logic [WIN_W-1:0]  win_frames_q;
  logic [TPS_W-1:0]  tps_q;
  logic [FR_W-1:0]   rate_limit_q;

  // latched beat
  logic [TIME_W-1:0] pts_q, arr_q;

  // statistics
  logic [TIME_W-1:0] last_arr_q, last_arr_d;
  logic [TIME_W-1:0] last_stamp_q, last_stamp_d;
  logic [TIME_W-1:0] wbase_q, wbase_d;
  logic [TIME_W-1:0] prev_q, prev_d;
  logic [TIME_W-1:0] cur_q, cur_d;
  logic [WIN_W-1:0]  frames_q, frames_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic [FR_W-1:0]   last_rep_q, last_rep_d;
  logic              chg_q, chg_d;
  logic              upd_q, upd_d;

  logic              out_valid_q, out_valid_d;
  pfre_out_t         out_q;

  logic [TIME_W-1:0] gap;
  logic              gap_clear;
  logic [TIME_W:0]   hi_bound;
  logic [TIME_W+1:0] three_p;
  logic              restart;
  logic [QUOT_W:0]   win_full;
  logic [RATE_W-1:0] win_rate;
  logic [FR_W-1:0]   lim_rate;

  logic              div_start, div_done, div_round;
  logic [QUOT_W-1:0] div_dividend, div_quo;
  logic [TIME_W-1:0] div_divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q  <= GAP_LIMIT_RST;
      win_frames_q <= WIN_FRAMES_RST;
      tps_q        <= TICKS_PER_SEC_RST;
      rate_limit_q <= RATE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAP_LIMIT:     gap_limit_q  <= cfg_data_i[TIME_W-1:0];
        CFG_WIN_FRAMES:    win_frames_q <= cfg_data_i[WIN_W-1:0];
        CFG_TICKS_PER_SEC: tps_q        <= cfg_data_i[TPS_W-1:0];
        CFG_RATE_LIMIT:    rate_limit_q <= cfg_data_i[FR_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pts_q <= in_data_i.pts;
      arr_q <= in_data_i.arrival_time;
    end
  end

  // arrival gap, absolute difference
  assign gap = (arr_q >= last_arr_q) ? arr_q - last_arr_q : last_arr_q - arr_q;
  assign gap_clear = (last_arr_q != '0) && (gap > gap_limit_q);

  // restart when interval leaves [floor(3p/4), p + floor(p/2)] or stamp is not past base
  assign hi_bound = {1'b0, prev_q} + {2'b00, prev_q[TIME_W-1:1]};
  assign three_p  = {2'b00, prev_q} + {1'b0, prev_q, 1'b0};
  assign restart  = ({1'b0, cur_q} > hi_bound) || (cur_q < three_p[TIME_W+1:2]) ||
                    (pts_q <= wbase_q);

  // window rate rounded to nearest with ties down, saturated
  assign win_full = {1'b0, div_quo} + {{QUOT_W{1'b0}}, div_round};
  assign win_rate = (win_full > (QUOT_W + 1)'(RATE_MAX)) ? RATE_MAX : win_full[RATE_W-1:0];

  assign lim_rate = (rate_q > {{(RATE_W - FR_W){1'b0}}, rate_limit_q}) ? '0 : rate_q[FR_W-1:0];

  always_comb begin
    last_arr_d   = last_arr_q;
    last_stamp_d = last_stamp_q;
    wbase_d      = wbase_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    frames_d     = frames_q;
    rate_d       = rate_q;
    last_rep_d   = last_rep_q;
    chg_d        = chg_q;
    upd_d        = upd_q;
    if (cmd_i.gap) begin
      if (gap_clear) begin
        last_stamp_d = '0;
        wbase_d      = '0;
        prev_d       = '0;
        cur_d        = '0;
        frames_d     = '0;
        rate_d       = '0;
        last_rep_d   = '0;
      end
      last_arr_d = arr_q;
    end
    if (cmd_i.interval) begin
      cur_d = pts_q - last_stamp_q;
    end
    if (cmd_i.skip) begin
      chg_d = 1'b0;
      upd_d = 1'b0;
    end
    if (cmd_i.jump && restart) begin
      wbase_d  = pts_q;
      frames_d = '0;
    end
    if (cmd_i.win_finish) begin
      rate_d   = win_rate;
      frames_d = '0;
      wbase_d  = pts_q;
    end
    if (cmd_i.init_finish) begin
      rate_d = div_quo[RATE_W-1:0];
    end
    if (cmd_i.tail) begin
      frames_d     = frames_q + WIN_W'(1);
      prev_d       = cur_q;
      last_stamp_d = pts_q;
    end
    if (cmd_i.limit) begin
      rate_d     = {{(RATE_W - FR_W){1'b0}}, lim_rate};
      chg_d      = last_rep_q != lim_rate;
      last_rep_d = lim_rate;
      upd_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_arr_q   <= '0;
      last_stamp_q <= '0;
      wbase_q      <= '0;
      prev_q       <= '0;
      cur_q        <= '0;
      frames_q     <= '0;
      rate_q       <= '0;
      last_rep_q   <= '0;
      chg_q        <= 1'b0;
      upd_q        <= 1'b0;
    end else begin
      last_arr_q   <= last_arr_d;
      last_stamp_q <= last_stamp_d;
      wbase_q      <= wbase_d;
      prev_q       <= prev_d;
      cur_q        <= cur_d;
      frames_q     <= frames_d;
      rate_q       <= rate_d;
      last_rep_q   <= last_rep_d;
      chg_q        <= chg_d;
      upd_q        <= upd_d;
    end
  end

  // shared divider: window rate or initial ticks/interval estimate
  assign div_start    = cmd_i.win_start | cmd_i.init_start;
  assign div_dividend = cmd_i.win_start ? QUOT_W'(win_frames_q) * QUOT_W'(tps_q)
                                        : QUOT_W'(tps_q);
  assign div_divisor  = cmd_i.win_start ? pts_q - wbase_q : cur_q;

  pfre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .round_o    (div_round)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.frame_rate   <= last_rep_q;
      out_q.rate_changed <= chg_q;
      out_q.updated      <= upd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.upd      = (pts_q != last_stamp_q) && (pts_q != '0);
  assign stat_o.iv_ok    = (last_stamp_q != '0) && (pts_q > last_stamp_q);
  assign stat_o.win_go   = (frames_q == win_frames_q) && (pts_q != wbase_q);
  assign stat_o.init_go  = rate_q == '0;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

/* hw/rtl/pfre_ctrl.sv */
module pfre_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pfre_pkg::pfre_stat_t stat_i,
  output pfre_pkg::pfre_cmd_t  cmd_o
);
  import pfre_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_GAP    = 4'd1;
  localparam logic [3:0] S_EVAL   = 4'd2;
  localparam logic [3:0] S_JUMP   = 4'd3;
  localparam logic [3:0] S_WCHK   = 4'd4;
  localparam logic [3:0] S_WDIV   = 4'd5;
  localparam logic [3:0] S_WFIN   = 4'd6;
  localparam logic [3:0] S_ICHK   = 4'd7;
  localparam logic [3:0] S_IDIV   = 4'd8;
  localparam logic [3:0] S_IFIN   = 4'd9;
  localparam logic [3:0] S_TAIL   = 4'd10;
  localparam logic [3:0] S_LIMIT  = 4'd11;
  localparam logic [3:0] S_RESULT = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_GAP;
        end
      end
      S_GAP: begin
        cmd_o.gap = 1'b1;
        state_d   = S_EVAL;
      end
      S_EVAL: begin
        if (!stat_i.upd) begin
          cmd_o.skip = 1'b1;
          state_d    = S_RESULT;
        end else if (stat_i.iv_ok) begin
          cmd_o.interval = 1'b1;
          state_d        = S_JUMP;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_JUMP: begin
        cmd_o.jump = 1'b1;
        state_d    = S_WCHK;
      end
      S_WCHK: begin
        if (stat_i.win_go) begin
          cmd_o.win_start = 1'b1;
          state_d         = S_WDIV;
        end else begin
          state_d = S_ICHK;
        end
      end
      S_WDIV: begin
        if (stat_i.div_done) begin
          state_d = S_WFIN;
        end
      end
      S_WFIN: begin
        cmd_o.win_finish = 1'b1;
        state_d          = S_ICHK;
      end
      S_ICHK: begin
        if (stat_i.init_go) begin
          cmd_o.init_start = 1'b1;
          state_d          = S_IDIV;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_IDIV: begin
        if (stat_i.div_done) begin
          state_d = S_IFIN;
        end
      end
      S_IFIN: begin
        cmd_o.init_finish = 1'b1;
        state_d           = S_TAIL;
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = S_LIMIT;
      end
      S_LIMIT: begin
        cmd_o.limit = 1'b1;
        state_d     = S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

/* hw/rtl/pts_frame_rate_estimator.sv */
// Frame rate estimator: each input beat carries one frame's presentation timestamp and its
// arrival time, and yields exactly one output beat with the current rate in frames per second
// (zero when unknown), a flag set when that rate differs from the last one reported, and a flag
// set when the timestamp was new and nonzero. An arrival gap above gap_limit clears all
// statistics first. Intervals are averaged over window_frames steady frames and the rate is
// window_frames*ticks_per_second/span, rounded to nearest with ties down; before the first full
// window it is ticks_per_second/interval. Rates above rate_limit read as zero. One beat is
// processed at a time. Every beat passes the gap check; a stale or zero timestamp then goes
// straight to the result, a new one also takes the tail and limit steps, and one that yields an
// interval first takes the jump, window and initial checks, running the window rate, the
// initial estimate or both on the shared one-bit-per-cycle divider. A finished result waits in
// the output register while the next beat is taken in. Configuration must be written through
// the plain write port only while the block is idle; the block itself does not enforce this.
module pts_frame_rate_estimator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pfre_pkg::pfre_in_t             in_data_i,
  // output beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pfre_pkg::pfre_out_t            out_data_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [pfre_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pfre_pkg::CFG_W-1:0]     cfg_data_i
);
  import pfre_pkg::*;

  pfre_cmd_t  cmd;
  pfre_stat_t stat;

  // sequencer: steps through gap check, interval test, window and initial divisions
  pfre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // statistics, config registers, shared divider and output register
  pfre_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // at most one step strobe per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd))
    else $error("more than one datapath step in a cycle");

  // a result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.emit |-> stat.out_free)
    else $error("result emitted while output register is held");

  // once a beat is taken the block is busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  // a rate change is only reported for an updating frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rate_changed) |-> out_data_o.updated)
    else $error("rate change flagged without update");

endmodule

/* tb/sv/pts_frame_rate_estimator_tb.sv */
module pts_frame_rate_estimator_tb;
  import pfre_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 400;    // long output hold-off
  localparam int unsigned QUIET_LIMIT  = 20000;  // cycles without any beat before giving up
  localparam int unsigned DRAIN_CYCLES = 100;    // longer than the worst processing of one beat
  localparam int unsigned SETTLE       = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input side
  logic     in_valid = 1'b0;
  logic     in_stall;
  pfre_in_t in_beat  = '0;

  // output side
  logic      out_valid;
  logic      out_stall = 1'b0;
  pfre_out_t out_beat;

  // configuration port
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = CFG_GAP_LIMIT;
  logic [CFG_W-1:0]     cfg_data = '0;

  // traffic shaping
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  int errors       = 0;
  int quiet_cycles = 0;

  // expected output beats, oldest first
  pfre_out_t pending_rates[$];

  // estimator copy: configuration
  logic [TIME_W-1:0] est_gap_limit;
  logic [WIN_W-1:0]  est_window;
  logic [TPS_W-1:0]  est_tps;
  logic [FR_W-1:0]   est_rate_limit;

  // estimator copy: statistics
  logic [TIME_W-1:0] est_last_arrival;
  logic [TIME_W-1:0] est_last_stamp;
  logic [TIME_W-1:0] est_window_base;
  logic [TIME_W-1:0] est_prev_iv;
  logic [TIME_W-1:0] est_cur_iv;
  logic [WIN_W-1:0]  est_win_count;
  logic [RATE_W-1:0] est_rate;
  logic [FR_W-1:0]   est_last_rep;

  // stream generator state
  logic [TIME_W-1:0] gen_pts;
  logic [TIME_W-1:0] gen_arr;
  logic [TIME_W-1:0] gen_iv;

  always #5 clk_i = ~clk_i;

  pts_frame_rate_estimator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  function automatic void clear_stats();
    est_last_arrival = '0;
    est_last_stamp   = '0;
    est_window_base  = '0;
    est_prev_iv      = '0;
    est_cur_iv       = '0;
    est_win_count    = '0;
    est_rate         = '0;
    est_last_rep     = '0;
  endfunction

  function automatic void reset_model();
    est_gap_limit  = GAP_LIMIT_RST;
    est_window     = WIN_FRAMES_RST;
    est_tps        = TICKS_PER_SEC_RST;
    est_rate_limit = RATE_LIMIT_RST;
    clear_stats();
  endfunction

  // one frame through the estimator copy, returns the beat it must produce
  function automatic pfre_out_t predict_rate(pfre_in_t f);
    logic [TIME_W-1:0] gap;
    logic [63:0]       p;
    logic [63:0]       c;
    logic [63:0]       low;
    logic [63:0]       span;
    logic [63:0]       num;
    logic [63:0]       q;
    logic              jumped;
    pfre_out_t         r;
    r = '0;

    // long silence on the arrival clock wipes every statistic
    if (est_last_arrival != 0) begin
      gap = (f.arrival_time >= est_last_arrival) ? f.arrival_time - est_last_arrival
                                                 : est_last_arrival - f.arrival_time;
      if (gap > est_gap_limit) clear_stats();
    end
    est_last_arrival = f.arrival_time;

    // stale or missing stamp leaves the estimate alone
    if (f.pts != est_last_stamp && f.pts != 0) begin
      r.updated = 1'b1;
      if (est_last_stamp != 0 && f.pts > est_last_stamp) begin
        est_cur_iv = f.pts - est_last_stamp;
        p = 64'(est_prev_iv);
        c = 64'(est_cur_iv);
        low = 3 * (p >> 2) + ((3 * (p & 64'd3)) >> 2);
        jumped = (c > p && (c - p) > (p >> 1)) || c < low;
        // interval out of the steady band restarts the window
        if (jumped || f.pts <= est_window_base) begin
          est_window_base = f.pts;
          est_win_count   = '0;
        end
        // full window: averaged rate, rounded to nearest with ties down, saturated
        if (est_win_count == est_window) begin
          span = 64'(f.pts - est_window_base);
          if (span != 0) begin
            num = 64'(est_window) * 64'(est_tps);
            q = num / span;
            if (num % span > span / 2) q = q + 1;
            est_rate        = (q > 64'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
            est_win_count   = '0;
            est_window_base = f.pts;
          end
        end
        // no window yet: single interval estimate
        if (est_rate == 0 && est_cur_iv != 0) begin
          q = 64'(est_tps) / 64'(est_cur_iv);
          est_rate = q[RATE_W-1:0];
        end
      end
      est_win_count  = est_win_count + WIN_W'(1);
      est_prev_iv    = est_cur_iv;
      est_last_stamp = f.pts;
      if (est_rate > RATE_W'(est_rate_limit)) est_rate = '0;
      if (RATE_W'(est_last_rep) != est_rate) begin
        r.rate_changed = 1'b1;
        est_last_rep   = est_rate[FR_W-1:0];
      end
    end
    r.frame_rate = est_last_rep;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  // frame interval for a rate of 1 to 150 fps at the current tick rate
  function automatic logic [TIME_W-1:0] pick_interval();
    logic [TIME_W-1:0] iv;
    iv = TIME_W'(est_tps) / TIME_W'($urandom_range(1, 150));
    return (iv == 0) ? TIME_W'(1) : iv;
  endfunction

  function automatic logic [TIME_W-1:0] arrival_hop();
    if (est_gap_limit < 60000)
      return TIME_W'($urandom_range(0, int'(est_gap_limit) + 10));
    return TIME_W'($urandom_range(1, 60000));
  endfunction

  // offer one beat, hold it until taken, then log what it must produce
  task automatic send_frame(input logic [TIME_W-1:0] stamp, input logic [TIME_W-1:0] arrival);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= '{pts: stamp, arrival_time: arrival};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_rates.push_back(predict_rate(in_beat));
  endtask

  // stop offering and wait for every outstanding beat to come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write all four registers while the block is idle
  task automatic load_setup(input logic [TIME_W-1:0] gap, input logic [WIN_W-1:0] win,
                            input logic [TPS_W-1:0] tps, input logic [FR_W-1:0] lim);
    logic [CFG_IDX_W-1:0] regs [4];
    logic [CFG_W-1:0]     vals [4];
    regs = '{CFG_GAP_LIMIT, CFG_WIN_FRAMES, CFG_TICKS_PER_SEC, CFG_RATE_LIMIT};
    vals = '{CFG_W'(gap), CFG_W'(win), CFG_W'(tps), CFG_W'(lim)};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we         <= 1'b0;
    est_gap_limit  = gap;
    est_window     = win;
    est_tps        = tps;
    est_rate_limit = lim;
    @(posedge clk_i);
  endtask

  // mostly steady frames with random content, sprinkled with every kind of disturbance
  task automatic run_stream(input int n);
    int                sel;
    logic [TIME_W-1:0] jit;
    logic [TIME_W-1:0] stamp;
    gen_iv  = pick_interval();
    gen_pts = rand_time() >> $urandom_range(8, 47);
    gen_arr = rand_time() >> $urandom_range(8, 47);
    repeat (n) begin
      sel = $urandom_range(99);
      gen_arr += arrival_hop();
      if (sel < 70) begin
        // steady frame with a little jitter
        jit = gen_iv >> 4;
        gen_pts += gen_iv - jit + TIME_W'($urandom_range(0, 2 * int'(jit)));
      end else if (sel < 76) begin
        gen_pts += gen_iv * TIME_W'($urandom_range(2, 4));      // interval jumps up
      end else if (sel < 80) begin
        gen_pts += (gen_iv >> 1) + 1;                           // interval drops
      end else if (sel < 84) begin
        // repeated stamp
      end else if (sel < 90) begin
        gen_pts -= TIME_W'($urandom_range(0, int'(gen_iv)));    // stamp goes back
      end else if (sel < 92) begin
        gen_arr += est_gap_limit + TIME_W'($urandom_range(1, 1000));
      end else if (sel < 94) begin
        gen_arr -= TIME_W'($urandom_range(1, 100000));          // arrival clock goes back
      end else if (sel < 97) begin
        gen_iv = pick_interval();                               // new source rate
        gen_pts += gen_iv;
      end else begin
        gen_pts = rand_time();                                  // noise
        gen_arr = rand_time();
      end
      stamp = ($urandom_range(99) < 3) ? TIME_W'(0) : gen_pts;  // missing stamp now and then
      send_frame(stamp, gen_arr);
    end
  endtask

  // defaults straight out of reset
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_frame(0, 0);                              // no stamp, arrival never seen
    send_frame(1000, 1000);                        // first stamp, no interval yet
    send_frame(1000, 2000);                        // repeated stamp
    send_frame(34333, 35000);                      // first interval, initial estimate
    send_frame(67666, 68000);                      // steady
    send_frame(100999, 101000);
    send_frame(167665, 168000);                    // interval jumps above 3/2
    send_frame(184332, 185000);                    // interval falls below 3/4
    send_frame(170000, 190000);                    // stamp not increasing
    send_frame(171000, 191000);                    // short interval, estimate already held
    send_frame(204333, 6000000);                   // arrival gap clears everything
    send_frame(237666, 6030000);
    send_frame('1, '1);                            // all-ones extremes, gap clear
    send_frame(1, 1);                              // backwards across the whole range
    send_frame(0, 2);                              // zero stamp again
  endtask

  task automatic test_config_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // one-frame window, fastest ticks: one-tick spans saturate the window rate
    load_setup('1, 1, '1, '1);
    for (int i = 0; i < 4; i++) send_frame(TIME_W'(100 + i), TIME_W'(50 + i));
    run_stream(30);
    // widest window, slowest ticks, zero gap tolerance
    load_setup('0, '1, 1, 1);
    run_stream(30);
    // zero window never has a span, zero limit hides every estimate
    load_setup(GAP_LIMIT_RST, 0, 90000, 0);
    run_stream(30);
  endtask

  task automatic test_long_windows();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // zero window: the 8-bit frame counter wraps back to zero and completes
    load_setup(GAP_LIMIT_RST, 0, 100000, '1);
    for (int i = 1; i <= 260; i++) send_frame(TIME_W'(1000 * i), TIME_W'(500 * i));
    // full 255-frame window
    load_setup(GAP_LIMIT_RST, '1, 100000, '1);
    for (int i = 1; i <= 260; i++)
      send_frame(TIME_W'(1000000 + 1000 * i), TIME_W'(200000 + 500 * i));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int               sel;
    logic [TIME_W-1:0] gap;
    logic [WIN_W-1:0]  win;
    logic [TPS_W-1:0]  tps;
    sel = $urandom_range(2);
    gap = (sel == 0) ? GAP_LIMIT_RST :
          (sel == 1) ? TIME_W'($urandom_range(1000, 100000)) : rand_time();
    sel = $urandom_range(9);
    win = (sel < 6) ? WIN_W'($urandom_range(1, 8)) :
          (sel < 8) ? WIN_W'($urandom_range(9, 64)) : WIN_W'($urandom_range(1, 255));
    sel = $urandom_range(2);
    tps = (sel == 0) ? TICKS_PER_SEC_RST :
          (sel == 1) ? TPS_W'(90000) : TPS_W'($urandom_range(1, 24'hFFFFFF));
    load_setup(gap, win, tps, FR_W'($urandom_range(1, 255)));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_stream(150);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_setup(GAP_LIMIT_RST, 4, TICKS_PER_SEC_RST, RATE_LIMIT_RST);
    // receiver blocks for a long stretch while beats keep coming
    hold_seq <= hold_seq + 1;
    run_stream(40);
    // sender waits for every result before going on
    wait_idle();
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    run_stream(20);
  endtask

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // every output beat against the oldest expectation
  always @(posedge clk_i) begin
    pfre_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_rates.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual rate %0d changed %0b updated %0b", $time,
                 out_beat.frame_rate, out_beat.rate_changed, out_beat.updated);
      end else begin
        want = pending_rates.pop_front();
        if (out_beat.frame_rate !== want.frame_rate) begin
          errors++;
          $display("%0t: frame_rate expected %0d actual %0d", $time,
                   want.frame_rate, out_beat.frame_rate);
        end
        if (out_beat.rate_changed !== want.rate_changed) begin
          errors++;
          $display("%0t: rate_changed expected %0b actual %0b", $time,
                   want.rate_changed, out_beat.rate_changed);
        end
        if (out_beat.updated !== want.updated) begin
          errors++;
          $display("%0t: updated expected %0b actual %0b", $time,
                   want.updated, out_beat.updated);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_extremes();
    test_long_windows();
    test_random_traffic(0, 0);
    test_random_traffic(76, 0);
    test_random_traffic(0, 76);
    test_random_traffic(13, 13);
    test_backpressure();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
